/* rtl/core/sem_pkg.sv */
// Package for the Sobel edge magnitude block: shared types and constants.
// No dependencies.
`default_nettype none
package sem_pkg;

    localparam int SEM_MAX_WIDTH = 2048;
    localparam int CFG_W         = 12;
    localparam int PIX_W         = 8;
    localparam int Q_DEPTH       = 8;
    localparam int Q_AW          = $clog2(Q_DEPTH);

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);
    localparam logic [CFG_W-1:0] MIN_DIM      = CFG_W'(3);

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [PIX_W-1:0] MAG_MAX = '1;

    typedef struct packed {
        logic valid;
        logic emit;
        logic row_end;
        logic frame_end;
    } t_ctl;

    typedef struct packed {
        logic [PIX_W-1:0] magnitude;
        logic             row_end;
        logic             frame_end;
    } t_res;

endpackage
`default_nettype wire

/* rtl/core/sobel_edge_magnitude.sv */
// Top level of the 3x3 Sobel edge magnitude block.
// Instantiates sem_front, sem_window and sem_back; uses sem_pkg.
//
// Input channel: i_valid / i_pixel / o_stall, 8-bit grayscale pixels in raster
// order. A transaction completes on a rising edge with i_valid high and
// o_stall low. Output channel: o_valid / o_magnitude / o_row_end /
// o_frame_end / i_stall. Each interior pixel yields |gx|+|gy| saturated at
// 255; border pixels yield nothing, so a frame gives (width-2) x (height-2)
// results. o_row_end flags the last result of a row, o_frame_end the last of
// the frame.
// Throughput: one pixel per cycle while o_stall is low. A result passes through
// the line store read and two arithmetic stages and is then written to the
// result queue, whose head is offered on the output.
// An 8-entry result queue decouples the channels; o_stall rises only when the
// queue plus the results in flight fill it, i.e. while i_stall holds back
// the output. Frame size is written through i_cfg_we / i_cfg_idx / i_cfg_data
// (0: width, 1: height) between frames. Synchronous reset returns to the
// frame origin with 640 x 480 and an empty queue; the line store needs no
// clearing since the first two rows of a frame fill it.
`default_nettype none
module sobel_edge_magnitude #(
    parameter int MAX_WIDTH = sem_pkg::SEM_MAX_WIDTH
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire logic [sem_pkg::PIX_W-1:0] i_pixel,
    output logic                           o_stall,
    output logic                           o_valid,
    output logic [sem_pkg::PIX_W-1:0]      o_magnitude,
    output logic                           o_row_end,
    output logic                           o_frame_end,
    input  wire logic                      i_stall,
    input  wire logic                      i_cfg_we,
    input  wire logic                      i_cfg_idx,
    input  wire logic [sem_pkg::CFG_W-1:0] i_cfg_data
);
    import sem_pkg::*;

    localparam int ADDR_W = $clog2(MAX_WIDTH);

    t_ctl              ctl;
    logic [ADDR_W-1:0] col;
    logic              push, out_fire;
    t_res              res, head;

    sem_front #(.MAX_WIDTH(MAX_WIDTH), .ADDR_W(ADDR_W)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_out_fire (out_fire),
        .o_ctl      (ctl),
        .o_col      (col)
    );

    sem_window #(.MAX_WIDTH(MAX_WIDTH), .ADDR_W(ADDR_W)) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_col   (col),
        .i_pixel (i_pixel),
        .o_push  (push),
        .o_res   (res)
    );

    sem_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (res),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (head),
        .o_fire  (out_fire)
    );

    assign o_magnitude = head.magnitude;
    assign o_row_end   = head.row_end;
    assign o_frame_end = head.frame_end;

endmodule
`default_nettype wire

/* rtl/core/sem_front.sv */
// Front end: input acceptance, configuration registers, raster counters,
// classification of each pixel and output credit tracking. Uses sem_pkg.
`default_nettype none
module sem_front #(
    parameter int MAX_WIDTH = sem_pkg::SEM_MAX_WIDTH,
    parameter int ADDR_W    = $clog2(MAX_WIDTH)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic                     i_cfg_we,
    input  wire logic                     i_cfg_idx,
    input  wire logic [sem_pkg::CFG_W-1:0] i_cfg_data,
    input  wire logic                     i_out_fire,
    output sem_pkg::t_ctl                 o_ctl,
    output logic [ADDR_W-1:0]             o_col
);
    import sem_pkg::*;

    localparam int EW = (CFG_W > $clog2(MAX_WIDTH + 1)) ? CFG_W : $clog2(MAX_WIDTH + 1);
    localparam logic [EW-1:0]     MAXW     = EW'(MAX_WIDTH);
    localparam logic [ADDR_W-1:0] LAST_COL = ADDR_W'(MAX_WIDTH - 1);
    localparam logic [Q_AW:0]     CREDITS  = (Q_AW + 1)'(Q_DEPTH);

    logic [CFG_W-1:0]  r_width, r_height;
    logic [ADDR_W-1:0] r_col, n_col;
    logic [CFG_W-1:0]  r_row, n_row;
    logic [Q_AW:0]     r_credit, n_credit;

    logic [EW-1:0]     w_eff;
    logic [CFG_W-1:0]  h_eff;
    logic [ADDR_W-1:0] c_eff;
    logic [EW:0]       col_p1;
    logic [CFG_W:0]    row_p1;
    logic              last_col, last_row, emit, accept;

    assign o_stall = (r_credit == CREDITS);
    assign accept  = i_valid && !o_stall;

    always_comb begin
        if (EW'(r_width) < EW'(MIN_DIM)) begin
            w_eff = EW'(MIN_DIM);
        end else if (EW'(r_width) > MAXW) begin
            w_eff = MAXW;
        end else begin
            w_eff = EW'(r_width);
        end
        h_eff    = (r_height < MIN_DIM) ? MIN_DIM : r_height;
        c_eff    = (r_col > LAST_COL) ? LAST_COL : r_col;
        col_p1   = (EW + 1)'(c_eff) + (EW + 1)'(1);
        row_p1   = {1'b0, r_row} + (CFG_W + 1)'(1);
        last_col = col_p1 >= {1'b0, w_eff};
        last_row = row_p1 >= {1'b0, h_eff};
        emit     = (r_row >= CFG_W'(2)) && (c_eff >= ADDR_W'(2));

        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : row_p1[CFG_W-1:0];
            end else begin
                n_col = col_p1[ADDR_W-1:0];
            end
        end
        n_credit = r_credit + (Q_AW + 1)'(accept && emit) - (Q_AW + 1)'(i_out_fire);
    end

    assign o_ctl = '{valid: accept, emit: emit, row_end: last_col,
                     frame_end: last_col && last_row};
    assign o_col = c_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_col    <= '0;
            r_row    <= '0;
            r_credit <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_WIDTH:  r_width  <= i_cfg_data;
                    REG_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
            r_col    <= n_col;
            r_row    <= n_row;
            r_credit <= n_credit;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/sem_window.sv */
// Datapath: line store, 3x3 window and Sobel kernels in a fixed
// three-stage pipeline that never stalls. Uses sem_pkg.
`default_nettype none
module sem_window #(
    parameter int MAX_WIDTH = sem_pkg::SEM_MAX_WIDTH,
    parameter int ADDR_W    = $clog2(MAX_WIDTH)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire sem_pkg::t_ctl             i_ctl,
    input  wire logic [ADDR_W-1:0]         i_col,
    input  wire logic [sem_pkg::PIX_W-1:0] i_pixel,
    output logic                           o_push,
    output sem_pkg::t_res                  o_res
);
    import sem_pkg::*;

    localparam int SW = PIX_W + 2;

    // entry holds {row two above, row just above}
    logic [2*PIX_W-1:0] mem [MAX_WIDTH];

    logic [2*PIX_W-1:0] r_rd;
    logic [ADDR_W-1:0]  r_col1;
    logic [PIX_W-1:0]   r_px1;
    t_ctl               r_ctl1, r_ctl2, r_ctl3;
    logic [PIX_W-1:0]   r_win [6];
    logic [SW-1:0]      r_gxp, r_gxn, r_gyp, r_gyn;
    logic [SW-1:0]      r_agx, r_agy;

    logic [PIX_W-1:0] top, mid, bot;
    logic [SW-1:0]    gxp, gxn, gyp, gyn;
    logic signed [SW:0] gx, gy;
    logic [SW:0]      mag_sum;

    always_ff @(posedge i_clk) begin
        if (i_ctl.valid) begin
            r_rd <= mem[i_col];
        end
        if (r_ctl1.valid) begin
            mem[r_col1] <= {r_rd[PIX_W-1:0], r_px1};
        end
    end

    assign top = r_rd[2*PIX_W-1:PIX_W];
    assign mid = r_rd[PIX_W-1:0];
    assign bot = r_px1;

    always_comb begin
        gxp = SW'(top) + {1'b0, mid, 1'b0} + SW'(bot);
        gxn = SW'(r_win[0]) + {1'b0, r_win[1], 1'b0} + SW'(r_win[2]);
        gyp = SW'(r_win[2]) + {1'b0, r_win[5], 1'b0} + SW'(bot);
        gyn = SW'(r_win[0]) + {1'b0, r_win[3], 1'b0} + SW'(top);
        gx  = $signed({1'b0, r_gxp}) - $signed({1'b0, r_gxn});
        gy  = $signed({1'b0, r_gyp}) - $signed({1'b0, r_gyn});
        mag_sum = {1'b0, r_agx} + {1'b0, r_agy};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_ctl3 <= '0;
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
            r_ctl3 <= r_ctl2;
            if (r_ctl1.valid) begin
                r_win[0] <= r_win[3];
                r_win[1] <= r_win[4];
                r_win[2] <= r_win[5];
                r_win[3] <= top;
                r_win[4] <= mid;
                r_win[5] <= bot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_col1 <= i_col;
        r_px1  <= i_pixel;
        r_gxp  <= gxp;
        r_gxn  <= gxn;
        r_gyp  <= gyp;
        r_gyn  <= gyn;
        r_agx  <= gx[SW] ? SW'(-gx) : gx[SW-1:0];
        r_agy  <= gy[SW] ? SW'(-gy) : gy[SW-1:0];
    end

    assign o_push = r_ctl3.valid && r_ctl3.emit;
    assign o_res  = '{magnitude: (mag_sum > (SW + 1)'(MAG_MAX)) ? MAG_MAX
                                                               : mag_sum[PIX_W-1:0],
                      row_end: r_ctl3.row_end, frame_end: r_ctl3.frame_end};

endmodule
`default_nettype wire

/* rtl/core/sem_back.sv */
// Result queue and output channel. The head entry drives the output ports.
// Uses sem_pkg.
`default_nettype none
module sem_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire sem_pkg::t_res i_res,
    output logic               o_valid,
    input  wire logic          i_stall,
    output sem_pkg::t_res      o_res,
    output logic               o_fire
);
    import sem_pkg::*;

    t_res            r_q [Q_DEPTH];
    logic [Q_AW-1:0] r_wr, r_rdp;
    logic [Q_AW:0]   r_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_fire  = o_valid && !i_stall;
    assign o_res   = r_q[r_rdp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rdp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_AW'(1);
            end
            if (o_fire) begin
                r_rdp <= r_rdp + Q_AW'(1);
            end
            r_cnt <= r_cnt + (Q_AW + 1)'(i_push) - (Q_AW + 1)'(o_fire);
        end
    end

endmodule
`default_nettype wire

/* rtl/core/sem_checker.sv */
// Port-level checker for sobel_edge_magnitude, bound to the top level.
// No dependencies beyond the top-level ports.
`default_nettype none
module sem_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_stall,
    input wire logic o_valid,
    input wire logic o_row_end,
    input wire logic o_frame_end,
    input wire logic i_stall
);

    a_reset_in_ready: assert property (@(posedge i_clk) !i_rst_n |=> !o_stall)
        else $error("input stalled right after reset");

    a_reset_out_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_frame_end_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_end) |-> o_row_end)
        else $error("frame end without row end");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("output transaction dropped while stalled");

endmodule

bind sobel_edge_magnitude sem_checker u_sem_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .o_row_end   (o_row_end),
    .o_frame_end (o_frame_end),
    .i_stall     (i_stall)
);
`default_nettype wire
